// File: rtl/hxb_pkg.sv
// Package for the hex text to bytes parser: shared types, codes and helper functions.
// Used by hxb_ctrl, hxb_dpath and hex_text_to_bytes_parser_core.
package hxb_pkg;

   localparam int PAT_CAP = 4;
   localparam int WIN_W   = 3;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_DIGITS = 2'd1,
      MODE_SKIP   = 2'd2,
      MODE_HALT   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_PREFIX_CHARS = 3'd0,
      REG_PREFIX_LEN   = 3'd1,
      REG_SUFFIX_CHARS = 3'd2,
      REG_SUFFIX_LEN   = 3'd3,
      REG_SEP_CHARS    = 3'd4,
      REG_SEP_LEN      = 3'd5,
      REG_ALIGN_LEFT   = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_STEP = 3'd1,
      ST_FIN  = 3'd2,
      ST_EHI  = 3'd3,
      ST_ELO  = 3'd4,
      ST_EPUT = 3'd5
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic fin;
      logic emit_hi;
      logic emit_lo;
      logic emit_put;
      logic emit_done;
   } cmd_type;

   typedef struct packed {
      logic brk;
      logic emit_req;
      logic fin_emit;
      logic emit_over;
      logic out_free;
      logic eot;
   } status_type;

   function automatic logic [WIN_W-1:0] eff_len(input logic [2:0] n);
      eff_len = (n > 3'(PAT_CAP)) ? WIN_W'(PAT_CAP) : n;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
   endfunction

   // bit 4 flags a valid digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_value = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         hex_value = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         hex_value = {1'b1, 4'(c - 8'h57)};
      end else begin
         hex_value = 5'd0;
      end
   endfunction

   function automatic logic win_match(input logic [PAT_CAP-1:0][7:0] win,
                                      input logic [WIN_W-1:0] fill,
                                      input logic [31:0] chars,
                                      input logic [WIN_W-1:0] n);
      logic ok;
      ok = (fill >= n);
      for (int k = 0; k < PAT_CAP; k++) begin
         if (WIN_W'(k) < n && win[k] != chars[8*k +: 8]) begin
            ok = 1'b0;
         end
      end
      win_match = ok;
   endfunction

endpackage

// File: rtl/hxb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hxb_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hxb_ctrl.sv
// Sequencing state machine: accepts characters, steps the scanner, drains tokens.
// Depends on hxb_pkg.
module hxb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hxb_pkg::status_type sts,
   output hxb_pkg::cmd_type    cmd
);

   hxb_pkg::state_type state_ff, state_in;
   logic               ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hxb_pkg::ST_IDLE;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         hxb_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = hxb_pkg::ST_STEP;
         end
         hxb_pkg::ST_STEP: begin
            if (sts.emit_req) begin
               state_in = hxb_pkg::ST_EHI;
               ret_in   = 1'b1;
            end else if (sts.brk) begin
               state_in = sts.eot ? hxb_pkg::ST_FIN : hxb_pkg::ST_IDLE;
            end
         end
         hxb_pkg::ST_FIN: begin
            if (sts.fin_emit) begin
               state_in = hxb_pkg::ST_EHI;
               ret_in   = 1'b0;
            end else begin
               state_in = hxb_pkg::ST_IDLE;
            end
         end
         hxb_pkg::ST_EHI: begin
            if (sts.emit_over) begin
               state_in = ret_ff ? hxb_pkg::ST_STEP : hxb_pkg::ST_IDLE;
            end else begin
               state_in = hxb_pkg::ST_ELO;
            end
         end
         hxb_pkg::ST_ELO: state_in = hxb_pkg::ST_EPUT;
         hxb_pkg::ST_EPUT: begin
            if (sts.out_free) state_in = hxb_pkg::ST_EHI;
         end
         default: state_in = hxb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         hxb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         hxb_pkg::ST_STEP: cmd.step = 1'b1;
         hxb_pkg::ST_FIN:  cmd.fin = 1'b1;
         hxb_pkg::ST_EHI: begin
            cmd.emit_done = sts.emit_over;
            cmd.emit_hi   = !sts.emit_over;
         end
         hxb_pkg::ST_ELO:  cmd.emit_lo = 1'b1;
         hxb_pkg::ST_EPUT: cmd.emit_put = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/hxb_dpath.sv
// Datapath: config registers, lookahead window, scan mode, digit store and output register.
// Depends on hxb_pkg and hxb_ram.
module hxb_dpath #(
   parameter int MAX_TOKEN_DIGITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  hxb_pkg::cmd_type    cmd,
   output hxb_pkg::status_type sts
);

   localparam int AW = $clog2(MAX_TOKEN_DIGITS);
   localparam int CW = $clog2(MAX_TOKEN_DIGITS + 1);
   localparam int PW = $clog2(MAX_TOKEN_DIGITS + 2);
   localparam int XW = CW + 2;
   localparam int WW = hxb_pkg::WIN_W;
   localparam int PC = hxb_pkg::PAT_CAP;

   logic [31:0] prefix_chars_ff, suffix_chars_ff, sep_chars_ff;
   logic [2:0]  prefix_len_ff, suffix_len_ff, sep_len_ff;
   logic        align_left_ff;

   logic [PC-1:0][7:0] win_ff, win_in;
   logic [WW-1:0]      fill_ff, fill_in;
   hxb_pkg::mode_type   mode_ff, mode_in;
   logic               eot_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic               zflag_ff;
   logic [3:0]         hi_ff;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff, out_drop_ff, out_valid_ff;

   logic [WW-1:0] sep, pre, suf, need, kcon;
   logic          sep_m, pre_m, suf_m, skip_nosuf, brk, emit_req;
   logic [4:0]    hv;
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [3:0]    rd_data;
   logic          pad;
   logic [XW-1:0] nb, addr_x;
   logic          zflag;
   logic [3:0]    lo_nib;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_chars_ff <= '0;
         suffix_chars_ff <= '0;
         sep_chars_ff    <= '0;
         prefix_len_ff   <= '0;
         suffix_len_ff   <= '0;
         sep_len_ff      <= '0;
         align_left_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (hxb_pkg::reg_index_type'(csr_index))
            hxb_pkg::REG_PREFIX_CHARS: prefix_chars_ff <= csr_data;
            hxb_pkg::REG_PREFIX_LEN:   prefix_len_ff   <= csr_data[2:0];
            hxb_pkg::REG_SUFFIX_CHARS: suffix_chars_ff <= csr_data;
            hxb_pkg::REG_SUFFIX_LEN:   suffix_len_ff   <= csr_data[2:0];
            hxb_pkg::REG_SEP_CHARS:    sep_chars_ff    <= csr_data;
            hxb_pkg::REG_SEP_LEN:      sep_len_ff      <= csr_data[2:0];
            hxb_pkg::REG_ALIGN_LEFT:   align_left_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign sep   = hxb_pkg::eff_len(sep_len_ff);
   assign pre   = hxb_pkg::eff_len(prefix_len_ff);
   assign suf   = hxb_pkg::eff_len(suffix_len_ff);
   assign sep_m = (sep != '0) && hxb_pkg::win_match(win_ff, fill_ff, sep_chars_ff, sep);
   assign pre_m = hxb_pkg::win_match(win_ff, fill_ff, prefix_chars_ff, pre);
   assign suf_m = (suf != '0) && hxb_pkg::win_match(win_ff, fill_ff, suffix_chars_ff, suf);
   assign hv    = hxb_pkg::hex_value(win_ff[0]);
   assign skip_nosuf = (mode_ff == hxb_pkg::MODE_SKIP) && (suf == '0);

   always_comb begin
      need = WW'(1);
      if (mode_ff == hxb_pkg::MODE_START) begin
         if (sep > need) need = sep;
         if (pre > need) need = pre;
      end else if (mode_ff != hxb_pkg::MODE_HALT && suf > need) begin
         need = suf;
      end
   end

   assign brk = !skip_nosuf && ((fill_ff == '0) || (fill_ff < need && !eot_ff));

   // one scan decision per step
   always_comb begin
      kcon     = '0;
      mode_in  = mode_ff;
      emit_req = 1'b0;
      wr_en    = 1'b0;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.step) begin
         if (skip_nosuf) begin
            emit_req = 1'b1;
            mode_in  = hxb_pkg::MODE_START;
         end else if (!brk) begin
            case (mode_ff)
               hxb_pkg::MODE_START: begin
                  if (sep_m) begin
                     kcon = sep;
                  end else if (hxb_pkg::is_space(win_ff[0])) begin
                     kcon = WW'(1);
                  end else if (pre != '0) begin
                     if (pre_m) begin
                        kcon     = pre;
                        count_in = '0;
                        ovf_in   = 1'b0;
                        mode_in  = hxb_pkg::MODE_DIGITS;
                     end else begin
                        mode_in = hxb_pkg::MODE_HALT;
                     end
                  end else begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                     mode_in  = hxb_pkg::MODE_DIGITS;
                  end
               end
               hxb_pkg::MODE_DIGITS: begin
                  if (suf_m) begin
                     kcon     = suf;
                     emit_req = 1'b1;
                     mode_in  = hxb_pkg::MODE_START;
                  end else begin
                     kcon = WW'(1);
                     if (hv[4]) begin
                        if (count_ff < CW'(MAX_TOKEN_DIGITS)) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else if (suf != '0) begin
                        mode_in = hxb_pkg::MODE_SKIP;
                     end else begin
                        emit_req = 1'b1;
                        mode_in  = hxb_pkg::MODE_START;
                     end
                  end
               end
               hxb_pkg::MODE_SKIP: begin
                  if (suf_m) begin
                     kcon     = suf;
                     emit_req = 1'b1;
                     mode_in  = hxb_pkg::MODE_START;
                  end else begin
                     kcon = WW'(1);
                  end
               end
               default: kcon = fill_ff;
            endcase
         end
      end else if (cmd.fin) begin
         mode_in = hxb_pkg::MODE_START;
         if (!sts.fin_emit) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end else if (cmd.emit_done) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (cmd.accept) begin
         win_in[fill_ff[$clog2(PC)-1:0]] = req_tdata;
         fill_in = fill_ff + WW'(1);
      end else if (cmd.fin) begin
         win_in  = '0;
         fill_in = '0;
      end else if (kcon != '0) begin
         for (int i = 0; i < PC; i++) begin
            win_in[i] = (WW'(i) + kcon < WW'(PC)) ? win_ff[i + int'(kcon)] : 8'h00;
         end
         fill_in = fill_ff - kcon;
      end
   end

   // nibble readout
   assign pad    = count_ff[0] && !align_left_ff;
   assign nb     = (XW'(count_ff) + XW'(1)) >> 1;
   assign addr_x = pad ? XW'(pos_ff) - XW'(1) : XW'(pos_ff);
   assign zflag  = (pad && pos_ff == '0) || (addr_x >= XW'(count_ff));
   assign rd_addr = addr_x[AW-1:0];
   assign lo_nib = zflag_ff ? 4'h0 : rd_data;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.step || cmd.fin) begin
         pos_in = '0;
      end else if (cmd.emit_hi || cmd.emit_put) begin
         pos_in = pos_ff + PW'(1);
      end
   end

   hxb_ram #(.WIDTH(4), .DEPTH(MAX_TOKEN_DIGITS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (hv[3:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         mode_ff      <= hxb_pkg::MODE_START;
         eot_ff       <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         if (cmd.accept) eot_ff <= req_tlast;
         if (cmd.emit_put) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      zflag_ff <= zflag;
      if (cmd.emit_lo) hi_ff <= lo_nib;
      if (cmd.emit_put) begin
         out_byte_ff <= {hi_ff, lo_nib};
         out_last_ff <= (XW'(pos_ff >> 1) + XW'(1) == nb);
         out_drop_ff <= ovf_ff;
      end
   end

   assign sts.brk       = brk;
   assign sts.emit_req  = emit_req;
   assign sts.fin_emit  = (mode_ff == hxb_pkg::MODE_DIGITS) && (suf == '0);
   assign sts.emit_over = (XW'(pos_ff) >= (nb << 1));
   assign sts.out_free  = !out_valid_ff || rsp_tready;
   assign sts.eot       = eot_ff;

   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_drop_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule

// File: rtl/hex_text_to_bytes_parser_core.sv
// Top level of the hex text to bytes parser: controller plus datapath.
// Depends on hxb_pkg, hxb_ctrl, hxb_dpath and hxb_ram.
//
//   channel | direction | tdata          | tlast          | tuser
//   req     | in        | text_char      | end_of_text    | -
//   rsp     | out       | out_byte       | token_end      | digits_dropped
//   csr     | in        | csr_index 0..6 selects the register, csr_data the value
//
// A character takes an accept in ST_IDLE, then ST_STEP for each scan decision and for the
// step that stops the scan; a window of up to 4 held characters allows up to 8
// decisions. The last character of a text adds a pass through ST_FIN.
// A token drains byte by byte through ST_EHI, ST_ELO and ST_EPUT, using the single
// read port of the digit store; a full rsp side holds the drain. Reset is synchronous
// and needs no clearing pass. The csr channel is always ready.
module hex_text_to_bytes_parser_core #(
   parameter int MAX_TOKEN_DIGITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // digits_dropped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   hxb_pkg::cmd_type    cmd;
   hxb_pkg::status_type sts;

   assign csr_ready = 1'b1;

   hxb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hxb_dpath #(.MAX_TOKEN_DIGITS(MAX_TOKEN_DIGITS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: tb/hex_text_to_bytes_parser_core_tb.sv
// Testbench for hex_text_to_bytes_parser_core: streams hex text, predicts the token bytes.
// Depends on hxb_pkg and the RTL of hex_text_to_bytes_parser_core.
module hex_text_to_bytes_parser_core_tb;

   typedef struct packed {
      logic [7:0] val;
      logic       last;
      logic       drop;
   } byte_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      logic [7:0] xval;
      logic       xlast;
      logic       xdrop;
   } text_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [31:0] csr_data = 32'd0;

   byte_result_type pending_bytes[$];
   int mismatches = 0;
   int chars_sent = 0;
   logic hold_rsp = 1'b0;
   logic calm = 1'b0;

   // parser state mirror
   logic [31:0] pre_chars, suf_chars, sep_chars;
   logic [2:0]  pre_n, suf_n, sep_n;
   logic        pad_back;
   logic [7:0]  win [8];
   int          win_fill;
   hxb_pkg::mode_type scan;
   logic [3:0]  nibbles [64];
   int          ndigits;
   logic        lost;
   int          step_out;

   always #10 clock = ~clock;

   hex_text_to_bytes_parser_core dut (.*);

   function automatic int cap_len(logic [2:0] n);
      return (n > 3'd4) ? 4 : int'(n);
   endfunction

   function automatic logic win_hit(logic [31:0] chars, int n);
      if (win_fill < n) return 1'b0;
      for (int k = 0; k < n; k++) if (win[k] != chars[8*k +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void drop_chars(int k);
      int i;
      if (k > win_fill) k = win_fill;
      for (i = 0; i + k < win_fill; i++) win[i] = win[i+k];
      for (; i < 8; i++) win[i] = 8'd0;
      win_fill -= k;
   endfunction

   function automatic int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic [3:0] nib_at(int j, logic front);
      if (front) begin
         if (j == 0) return 4'd0;
         j--;
      end
      return (j < ndigits) ? nibbles[j] : 4'd0;
   endfunction

   function automatic void flush_token();
      int nb;
      logic front;
      byte_result_type r;
      nb = (ndigits + 1) / 2;
      front = ndigits[0] && !pad_back;
      for (int i = 0; i < nb; i++) begin
         r.val = {nib_at(2*i, front), nib_at(2*i+1, front)};
         r.last = (i + 1 == nb);
         r.drop = lost;
         if (step_out < 32) begin
            pending_bytes.push_back(r);
            step_out++;
         end
      end
      ndigits = 0;
      lost = 1'b0;
   endfunction

   function automatic void scan_text(logic eot);
      int sep, pre, suf, need, v;
      forever begin
         sep = cap_len(sep_n);
         pre = cap_len(pre_n);
         suf = cap_len(suf_n);
         need = 1;
         if (scan == hxb_pkg::MODE_SKIP && suf == 0) begin
            flush_token();
            scan = hxb_pkg::MODE_START;
            continue;
         end
         if (scan == hxb_pkg::MODE_START) begin
            if (sep > need) need = sep;
            if (pre > need) need = pre;
         end else if (scan != hxb_pkg::MODE_HALT && suf > need) begin
            need = suf;
         end
         if (win_fill == 0 || (win_fill < need && !eot)) break;
         case (scan)
            hxb_pkg::MODE_START: begin
               if (sep > 0 && win_hit(sep_chars, sep)) begin
                  drop_chars(sep);
               end else if (win[0] inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
                  drop_chars(1);
               end else if (pre > 0) begin
                  if (win_hit(pre_chars, pre)) begin
                     drop_chars(pre);
                     ndigits = 0;
                     lost = 1'b0;
                     scan = hxb_pkg::MODE_DIGITS;
                  end else begin
                     scan = hxb_pkg::MODE_HALT;
                  end
               end else begin
                  ndigits = 0;
                  lost = 1'b0;
                  scan = hxb_pkg::MODE_DIGITS;
               end
            end
            hxb_pkg::MODE_DIGITS: begin
               if (suf > 0 && win_hit(suf_chars, suf)) begin
                  drop_chars(suf);
                  flush_token();
                  scan = hxb_pkg::MODE_START;
               end else begin
                  v = digit_of(win[0]);
                  drop_chars(1);
                  if (v >= 0) begin
                     if (ndigits < 64) begin
                        nibbles[ndigits] = 4'(v);
                        ndigits++;
                     end else begin
                        lost = 1'b1;
                     end
                  end else if (suf > 0) begin
                     scan = hxb_pkg::MODE_SKIP;
                  end else begin
                     flush_token();
                     scan = hxb_pkg::MODE_START;
                  end
               end
            end
            hxb_pkg::MODE_SKIP: begin
               if (win_hit(suf_chars, suf)) begin
                  drop_chars(suf);
                  flush_token();
                  scan = hxb_pkg::MODE_START;
               end else begin
                  drop_chars(1);
               end
            end
            default: drop_chars(win_fill);
         endcase
      end
   endfunction

   function automatic void predict_char(logic [7:0] ch, logic eot);
      step_out = 0;
      if (win_fill < 8) begin
         win[win_fill] = ch;
         win_fill++;
      end
      scan_text(eot);
      if (eot) begin
         if (scan == hxb_pkg::MODE_DIGITS && cap_len(suf_n) == 0) flush_token();
         ndigits = 0;
         lost = 1'b0;
         drop_chars(win_fill);
         scan = hxb_pkg::MODE_START;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic send_char(logic [7:0] ch, logic eot, logic typed = 1'b0,
                            byte_result_type typed_res = '0);
      int gap;
      int before_n;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      before_n = pending_bytes.size();
      predict_char(ch, eot);
      if (typed) begin
         while (pending_bytes.size() > before_n) void'(pending_bytes.pop_back());
         pending_bytes.push_back(typed_res);
      end
      chars_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(hxb_pkg::reg_index_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         hxb_pkg::REG_PREFIX_CHARS: pre_chars = v;
         hxb_pkg::REG_PREFIX_LEN:   pre_n = v[2:0];
         hxb_pkg::REG_SUFFIX_CHARS: suf_chars = v;
         hxb_pkg::REG_SUFFIX_LEN:   suf_n = v[2:0];
         hxb_pkg::REG_SEP_CHARS:    sep_chars = v;
         hxb_pkg::REG_SEP_LEN:      sep_n = v[2:0];
         hxb_pkg::REG_ALIGN_LEFT:   pad_back = v[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [7:0] pattern_char();
      case ($urandom_range(6))
         0: return ",";
         1: return ";";
         2: return "x";
         3: return "0";
         4: return "#";
         5: return "h";
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [31:0] pattern_word();
      logic [31:0] w;
      if ($urandom_range(9) == 0) return 32'hFFFF_FFFF;
      for (int k = 0; k < 4; k++) w[8*k +: 8] = pattern_char();
      return w;
   endfunction

   function automatic logic [2:0] pattern_len();
      int r;
      r = $urandom_range(9);
      if (r < 4) return 3'd0;
      if (r == 9) return 3'($urandom_range(7, 5));
      return 3'($urandom_range(4, 1));
   endfunction

   task automatic put_pattern(ref logic [7:0] txt[$], input logic [31:0] w, input logic [2:0] n);
      for (int k = 0; k < cap_len(n); k++) txt.push_back(w[8*k +: 8]);
   endtask

   task automatic send_text();
      logic [7:0] txt[$];
      int ntok, nd;
      logic [3:0] d;
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(12, 1)) txt.push_back(8'($urandom_range(255)));
      end else begin
         ntok = $urandom_range(4, 1);
         for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(1)) put_pattern(txt, sep_chars, sep_n);
            repeat ($urandom_range(2)) txt.push_back(8'h20);
            if ($urandom_range(15) != 0) put_pattern(txt, pre_chars, pre_n);
            nd = ($urandom_range(24) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
            repeat (nd) begin
               d = 4'($urandom_range(15));
               if (d < 10) txt.push_back(8'("0" + d));
               else txt.push_back(8'(($urandom_range(1) ? "a" : "A") + d - 10));
            end
            if (cap_len(suf_n) > 0) begin
               if ($urandom_range(2) == 0) txt.push_back("z");
               if ($urandom_range(7) != 0) put_pattern(txt, suf_chars, suf_n);
            end else begin
               txt.push_back($urandom_range(1) ? 8'h20 : ",");
            end
         end
         if ($urandom_range(3) == 0) void'(txt.pop_back());
         if (txt.size() == 0) txt.push_back("7");
      end
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
   endtask

   localparam int DIRECTED_ROWS = 12;
   text_row_type directed_rows [DIRECTED_ROWS] = '{
      '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{" ",   1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
      '{"F",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{"f",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},
      '{"a",   1'b1, 1'b1, 8'h0A, 1'b1, 1'b0},
      '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{"1",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{"2",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{"3",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{",",   1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
   };

   always @(posedge clock) begin
      byte_result_type got, want;
      int r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tlast, rsp_tuser};
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected byte %h last %b drop %b",
                                           got.val, got.last, got.drop);
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("byte exp %h/%b/%b got %h/%b/%b", want.val, want.last,
                           want.drop, got.val, got.last, got.drop);
            end
         end
      end
      r = $urandom_range(99);
      rsp_tready <= !reset && !hold_rsp && (calm || r < 60 || (r >= 97 ? 1'b0 : r < 90));
   end

   initial begin
      wait (chars_sent > 120);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      pre_chars = 0; pre_n = 0; suf_chars = 0; suf_n = 0;
      sep_chars = 0; sep_n = 0; pad_back = 0;
      foreach (win[i]) win[i] = 8'd0;
      win_fill = 0;
      scan = hxb_pkg::MODE_START;
      ndigits = 0;
      lost = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                   '{directed_rows[i].xval, directed_rows[i].xlast, directed_rows[i].xdrop});
      settle();
      while (chars_sent < 420) begin
         calm <= ($urandom_range(4) == 0);
         write_reg(hxb_pkg::REG_PREFIX_CHARS, pattern_word());
         write_reg(hxb_pkg::REG_PREFIX_LEN, 32'(pattern_len()));
         write_reg(hxb_pkg::REG_SUFFIX_CHARS, pattern_word());
         write_reg(hxb_pkg::REG_SUFFIX_LEN, 32'(pattern_len()));
         write_reg(hxb_pkg::REG_SEP_CHARS, pattern_word());
         write_reg(hxb_pkg::REG_SEP_LEN, 32'(pattern_len()));
         write_reg(hxb_pkg::REG_ALIGN_LEFT, 32'($urandom_range(1)));
         repeat ($urandom_range(5, 2)) send_text();
         settle();
      end
      write_reg(hxb_pkg::REG_PREFIX_LEN, 32'd7);
      write_reg(hxb_pkg::REG_SUFFIX_LEN, 32'd7);
      write_reg(hxb_pkg::REG_SEP_LEN, 32'd7);
      write_reg(hxb_pkg::REG_ALIGN_LEFT, 32'd1);
      send_text();
      settle();
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
